// ----- rtl/sme_pkg.sv -----
// Shared types and constants for the stack machine execute block.
package sme_pkg;

   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

   // Instruction opcodes
   typedef enum logic [4:0] {
      OP_NEG       = 5'd0,
      OP_NOT       = 5'd1,
      OP_ADD       = 5'd2,
      OP_SUB       = 5'd3,
      OP_MUL       = 5'd4,
      OP_DIV       = 5'd5,
      OP_EQ        = 5'd6,
      OP_NEQ       = 5'd7,
      OP_LT        = 5'd8,
      OP_LTE       = 5'd9,
      OP_GT        = 5'd10,
      OP_GTE       = 5'd11,
      OP_AND       = 5'd12,
      OP_OR        = 5'd13,
      OP_LOAD      = 5'd14,
      OP_SAVE      = 5'd15,
      OP_PUSH      = 5'd16,
      OP_TRUE      = 5'd17,
      OP_PUSH_ZERO = 5'd18,
      OP_JUMP      = 5'd19,
      OP_JUMPIF    = 5'd20,
      OP_ADJUST    = 5'd21
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_UNDER   = 3'd1,
      STAT_OVER    = 3'd2,
      STAT_INDEX   = 3'd3,
      STAT_DIVZERO = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_DECODE,
      STATE_READ_A,
      STATE_READ_B,
      STATE_OPERAND,
      STATE_EXEC,
      STATE_MULDIV,
      STATE_WRITE,
      STATE_READ_TOP,
      STATE_DONE
   } state_type;

   // Start request to the multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } md_ctl_type;

endpackage

// ----- rtl/stack_machine_execute.sv -----
// Stack machine execute: top level with the instruction sequencer.
//
// Executes one stack-machine instruction per transaction on a Q32.32 (FRAC_BITS)
// datapath and returns one result transaction: program-counter advance, new top
// of stack, depth and status. After reset the block clears its stack memory,
// one entry a cycle, before it raises req_tready. Multiply and divide run in the
// bit-serial multiply/divide unit that produces one product or quotient bit a
// cycle. The next instruction is taken once the result has moved into the output
// register.
module stack_machine_execute #(
   parameter int STACK_DEPTH = 64,
   parameter int FRAC_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // imm_value[63:0], imm_index[80:64], zero fill
   input  logic [4:0]  req_tuser,   // req_type[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // pc_advance[17:0], top_value[81:18],
                                    // stack_depth[88:82], status[91:89], zero fill
);
   import sme_pkg::*;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;

   state_type   state_ff,  state_in;
   op_type      op_ff,     op_in;
   logic [63:0] imm_ff,    imm_in;
   logic [16:0] idx_ff,    idx_in;
   logic [SP_W-1:0]  sp_ff,   sp_in;
   logic [SP_W-1:0]  nsp_ff,  nsp_in;
   logic [SP_W-1:0]  clr_ff,  clr_in;
   status_type  status_ff, status_in;
   logic [17:0] adv_ff,    adv_in;
   logic        wen_ff,    wen_in;
   logic [IDX_W-1:0] waddr_ff, waddr_in;
   logic [IDX_W-1:0] rd1_ff,   rd1_in;
   logic [IDX_W-1:0] rd2_ff,   rd2_in;
   logic [63:0] a_ff,      a_in;
   logic [63:0] b_ff,      b_in;
   logic [63:0] wdata_ff,  wdata_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff,  rsp_data_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [63:0]      mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   logic [63:0]      mem_rdata;
   logic [63:0]      alu_result;
   md_ctl_type       md_ctl;
   logic             md_done;
   logic [63:0]      md_result;

   logic             idx_in_mem;
   logic             idx_in_depth;
   logic             sp_empty;
   logic             sp_lt2;
   logic             sp_full;
   logic [17:0]      jump_adv;
   logic [IDX_W-1:0] sp_m1;
   logic [IDX_W-1:0] sp_m2;
   logic [IDX_W-1:0] sp_p0;
   logic [SP_W+6:0]  depth_ext;
   logic [63:0]      top_val;

   assign idx_in_mem   = !idx_ff[16] && (idx_ff < 17'(STACK_DEPTH));
   assign idx_in_depth = !idx_ff[16] && (idx_ff <= 17'(STACK_DEPTH));
   assign sp_empty     = sp_ff == '0;
   assign sp_lt2       = sp_ff < SP_W'(2);
   assign sp_full      = sp_ff == SP_W'(STACK_DEPTH);
   assign jump_adv     = 18'd1 + {idx_ff[16], idx_ff};
   assign sp_m1        = IDX_W'(sp_ff - SP_W'(1));
   assign sp_m2        = IDX_W'(sp_ff - SP_W'(2));
   assign sp_p0        = IDX_W'(sp_ff);
   assign depth_ext    = {7'd0, sp_ff};
   assign top_val      = sp_empty ? 64'd0 : mem_rdata;

   sme_ram #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sme_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .op     (op_ff),
      .a      (a_ff),
      .b      (b_ff),
      .result (alu_result)
   );

   sme_muldiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .a      (a_ff),
      .b      (b_ff),
      .done   (md_done),
      .result (md_result)
   );

   // Memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = waddr_ff;
      mem_wdata = wdata_ff;
      if (state_ff == STATE_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(clr_ff);
         mem_wdata = '0;
      end else if (state_ff == STATE_WRITE) begin
         mem_we = wen_ff;
      end
      if (state_ff == STATE_READ_A) begin
         mem_raddr = rd1_ff;
      end else if (state_ff == STATE_READ_B) begin
         mem_raddr = rd2_ff;
      end else begin
         mem_raddr = sp_m1;
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      idx_in       = idx_ff;
      sp_in        = sp_ff;
      nsp_in       = nsp_ff;
      clr_in       = clr_ff;
      status_in    = status_ff;
      adv_in       = adv_ff;
      wen_in       = wen_ff;
      waddr_in     = waddr_ff;
      rd1_in       = rd1_ff;
      rd2_in       = rd2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      wdata_in     = wdata_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      md_ctl       = '0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         STATE_CLEAR: begin
            clr_in = clr_ff + SP_W'(1);
            if (clr_ff == SP_W'(STACK_DEPTH - 1)) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               imm_in   = req_tdata[63:0];
               idx_in   = req_tdata[80:64];
               state_in = STATE_DECODE;
            end
         end
         STATE_DECODE: begin
            status_in = STAT_OK;
            adv_in    = 18'd1;
            wen_in    = 1'b0;
            nsp_in    = sp_ff;
            waddr_in  = sp_p0;
            rd1_in    = '0;
            rd2_in    = '0;
            unique case (op_ff)
               OP_NEG, OP_NOT: begin
                  if (sp_empty) begin
                     status_in = STAT_UNDER;
                  end else begin
                     rd2_in   = sp_m1;
                     wen_in   = 1'b1;
                     waddr_in = sp_m1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ, OP_LT, OP_LTE,
               OP_GT, OP_GTE, OP_AND, OP_OR: begin
                  if (sp_lt2) begin
                     status_in = STAT_UNDER;
                  end else begin
                     rd1_in   = sp_m2;
                     rd2_in   = sp_m1;
                     wen_in   = 1'b1;
                     waddr_in = sp_m2;
                     nsp_in   = sp_ff - SP_W'(1);
                  end
               end
               OP_LOAD: begin
                  adv_in = 18'd2;
                  if (sp_full) begin
                     status_in = STAT_OVER;
                  end else if (!idx_in_mem) begin
                     status_in = STAT_INDEX;
                  end else begin
                     rd1_in = IDX_W'(idx_ff);
                     wen_in = 1'b1;
                     nsp_in = sp_ff + SP_W'(1);
                  end
               end
               OP_SAVE: begin
                  adv_in = 18'd2;
                  if (sp_empty) begin
                     status_in = STAT_UNDER;
                  end else if (!idx_in_mem) begin
                     status_in = STAT_INDEX;
                  end else begin
                     rd1_in   = sp_m1;
                     wen_in   = 1'b1;
                     waddr_in = IDX_W'(idx_ff);
                     nsp_in   = sp_ff - SP_W'(1);
                  end
               end
               OP_PUSH, OP_TRUE, OP_PUSH_ZERO: begin
                  if (op_ff == OP_PUSH) begin
                     adv_in = 18'd2;
                  end
                  if (sp_full) begin
                     status_in = STAT_OVER;
                  end else begin
                     wen_in = 1'b1;
                     nsp_in = sp_ff + SP_W'(1);
                  end
               end
               OP_JUMP: begin
                  adv_in = jump_adv;
               end
               OP_JUMPIF: begin
                  adv_in = 18'd2;
                  if (sp_empty) begin
                     status_in = STAT_UNDER;
                  end else begin
                     rd1_in = sp_m1;
                     nsp_in = sp_ff - SP_W'(1);
                  end
               end
               OP_ADJUST: begin
                  adv_in = 18'd2;
                  if (!idx_in_depth) begin
                     status_in = STAT_INDEX;
                  end else begin
                     nsp_in = SP_W'(idx_ff);
                  end
               end
               default: begin
                  adv_in = 18'd1;
               end
            endcase
            if (status_in == STAT_OK) begin
               state_in = STATE_READ_A;
            end else begin
               state_in = STATE_READ_TOP;
            end
         end
         STATE_READ_A: begin
            state_in = STATE_READ_B;
         end
         STATE_READ_B: begin
            a_in     = mem_rdata;
            state_in = STATE_OPERAND;
         end
         STATE_OPERAND: begin
            b_in     = mem_rdata;
            state_in = STATE_EXEC;
         end
         STATE_EXEC: begin
            state_in = STATE_WRITE;
            wdata_in = alu_result;
            unique case (op_ff)
               OP_MUL: begin
                  md_ctl.start = 1'b1;
                  state_in     = STATE_MULDIV;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     status_in = STAT_DIVZERO;
                     if (a_ff == '0) begin
                        wdata_in = '0;
                     end else begin
                        wdata_in = a_ff[63] ? SIGN64 : MAXPOS;
                     end
                  end else begin
                     md_ctl.start  = 1'b1;
                     md_ctl.is_div = 1'b1;
                     state_in      = STATE_MULDIV;
                  end
               end
               OP_LOAD, OP_SAVE: wdata_in = a_ff;
               OP_PUSH:          wdata_in = imm_ff;
               OP_TRUE:          wdata_in = ONE_FX;
               OP_PUSH_ZERO:     wdata_in = '0;
               OP_JUMPIF: begin
                  if (a_ff == '0) begin
                     adv_in = jump_adv;
                  end
               end
               default: wdata_in = alu_result;
            endcase
         end
         STATE_MULDIV: begin
            if (md_done) begin
               wdata_in = md_result;
               state_in = STATE_WRITE;
            end
         end
         STATE_WRITE: begin
            sp_in    = nsp_ff;
            state_in = STATE_READ_TOP;
         end
         STATE_READ_TOP: begin
            state_in = STATE_DONE;
         end
         STATE_DONE: begin
            // Load the output register once the previous result is gone
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, status_ff, depth_ext[6:0], top_val, adv_ff};
               state_in     = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         sp_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      imm_ff      <= imm_in;
      idx_ff      <= idx_in;
      nsp_ff      <= nsp_in;
      status_ff   <= status_in;
      adv_ff      <= adv_in;
      wen_ff      <= wen_in;
      waddr_ff    <= waddr_in;
      rd1_ff      <= rd1_in;
      rd2_ff      <= rd2_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      wdata_ff    <= wdata_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/sme_ram.sv -----
// Stack memory: one write port, one registered read port.
module sme_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [63:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]       rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sme_alu.sv -----
// Combinational arithmetic, compare and logic unit for the simple opcodes.
module sme_alu #(
   parameter int FRAC_BITS = 32
) (
   input  sme_pkg::op_type op,
   input  logic [63:0]     a,
   input  logic [63:0]     b,
   output logic [63:0]     result
);
   import sme_pkg::*;

   localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;

   logic [63:0] sum;
   logic [63:0] diff;
   logic        lt_ab;
   logic        lt_ba;

   assign sum   = a + b;
   assign diff  = a - b;
   assign lt_ab = $signed(a) < $signed(b);
   assign lt_ba = $signed(b) < $signed(a);

   // Unary ops take their operand from b
   always_comb begin
      result = '0;
      unique case (op)
         OP_NEG: result = (b == SIGN64) ? MAXPOS : (64'd0 - b);
         OP_NOT: result = (b == '0) ? ONE_FX : '0;
         OP_ADD: begin
            if (((a ^ b) & SIGN64) == '0 && ((sum ^ a) & SIGN64) != '0) begin
               result = a[63] ? SIGN64 : MAXPOS;
            end else begin
               result = sum;
            end
         end
         OP_SUB: begin
            if (((a ^ b) & SIGN64) != '0 && ((diff ^ a) & SIGN64) != '0) begin
               result = a[63] ? SIGN64 : MAXPOS;
            end else begin
               result = diff;
            end
         end
         OP_EQ:  result = (a == b) ? ONE_FX : '0;
         OP_NEQ: result = (a != b) ? ONE_FX : '0;
         OP_LT:  result = lt_ab ? ONE_FX : '0;
         OP_LTE: result = !lt_ba ? ONE_FX : '0;
         OP_GT:  result = lt_ba ? ONE_FX : '0;
         OP_GTE: result = !lt_ab ? ONE_FX : '0;
         OP_AND: result = (a != '0 && b != '0) ? ONE_FX : '0;
         OP_OR:  result = (a != '0 || b != '0) ? ONE_FX : '0;
         default: result = '0;
      endcase
   end

endmodule

// ----- rtl/sme_muldiv.sv -----
// Iterative fixed-point multiply (shift-add) and divide (restoring), one bit a cycle.
module sme_muldiv #(
   parameter int FRAC_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  sme_pkg::md_ctl_type ctl,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   output logic                done,
   output logic [63:0]         result
);
   import sme_pkg::*;

   localparam int NBITS = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(NBITS + 1);
   localparam logic [127:0] FRAC_MASK = (128'(1) << FRAC_BITS) - 128'(1);
   localparam logic [127:0] Q_MASK    = (128'(1) << NBITS) - 128'(1);

   logic             busy_ff,   busy_in;
   logic             fin_ff,    fin_in;
   logic             done_ff,   done_in;
   logic             div_ff,    div_in;
   logic             neg_ff,    neg_in;
   logic [63:0]      x_ff,      x_in;
   logic [63:0]      rem_ff,    rem_in;
   logic [127:0]     p_ff,      p_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic [63:0]      res_ff,    res_in;

   logic [63:0]  mag_a;
   logic [63:0]  mag_b;
   logic [64:0]  add_sum;
   logic [64:0]  rem_shift;
   logic [65:0]  rem_diff;
   logic         rem_ge;
   logic [127:0] q_full;
   logic [63:0]  q_hi;
   logic [63:0]  q_lo;
   logic         frac_rem;
   logic [63:0]  sat_lo;
   logic         sat_hit;

   assign mag_a = a[63] ? (64'd0 - a) : a;
   assign mag_b = b[63] ? (64'd0 - b) : b;

   // Adder (multiply) and subtractor (divide) datapath
   assign add_sum   = {1'b0, p_ff[127:64]} + (p_ff[0] ? {1'b0, x_ff} : 65'd0);
   assign rem_shift = {rem_ff, p_ff[NBITS-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b0, x_ff};
   assign rem_ge    = !rem_diff[65];

   // Post-processing: scale and round products, saturate products and quotients
   always_comb begin
      if (div_ff) begin
         q_full   = p_ff & Q_MASK;
         frac_rem = 1'b0;
      end else begin
         q_full   = p_ff >> FRAC_BITS;
         frac_rem = (p_ff & FRAC_MASK) != '0;
      end
      q_hi    = q_full[127:64];
      q_lo    = q_full[63:0];
      sat_hit = 1'b0;
      sat_lo  = q_lo;
      if (neg_ff && frac_rem && q_hi == '0) begin
         if (q_lo >= SIGN64) begin
            sat_hit = 1'b1;
         end else begin
            sat_lo = q_lo + 64'd1;
         end
      end
      if (neg_ff) begin
         if (sat_hit || q_hi != '0 || sat_lo > SIGN64) begin
            res_in = SIGN64;
         end else begin
            res_in = 64'd0 - sat_lo;
         end
      end else begin
         if (q_hi != '0 || sat_lo > MAXPOS) begin
            res_in = MAXPOS;
         end else begin
            res_in = sat_lo;
         end
      end
      if (!fin_ff) begin
         res_in = res_ff;
      end
   end

   // Iteration control
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         neg_in  = a[63] ^ b[63];
         cnt_in  = '0;
         rem_in  = '0;
         if (ctl.is_div) begin
            x_in = mag_b;
            p_in = {64'd0, mag_a} << FRAC_BITS;
         end else begin
            x_in = mag_a;
            p_in = {64'd0, mag_b};
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (div_ff) begin
            rem_in = rem_ge ? rem_diff[63:0] : rem_shift[63:0];
            p_in   = {p_ff[126:0], rem_ge};
            if (cnt_ff == CNT_W'(NBITS - 1)) begin
               busy_in = 1'b0;
               fin_in  = 1'b1;
            end
         end else begin
            p_in = {add_sum, p_ff[63:1]};
            if (cnt_ff == CNT_W'(63)) begin
               busy_in = 1'b0;
               fin_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      rem_ff <= rem_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the stack machine execute block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sme_pkg::*;

   localparam int DEPTH = 64;
   localparam int FRAC  = 32;

   typedef struct {
      logic [4:0]  opcode;
      logic [63:0] literal;
      logic [16:0] index;
   } instr_type;

   typedef struct {
      logic [17:0] pc_adv;
      logic [63:0] top;
      logic [6:0]  depth;
      logic [2:0]  status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // imm_value[63:0], imm_index[80:64], zero fill
   logic [4:0]  req_tuser = '0;   // req_type[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // pc_advance[17:0], top_value[81:18],
                                  // stack_depth[88:82], status[91:89], zero fill

   instr_type   pending_instrs[$];
   outcome_type expected_outcomes[$];
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   int       mismatches = 0;
   bit       req_taken = 1'b0;
   bit       timed_out = 1'b0;
   int       plan_depth = 0;

   // Predictor state
   logic [63:0] shadow_mem[DEPTH];
   int          shadow_sp = 0;

   stack_machine_execute u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp a wide signed value into the 64-bit signed range
   function automatic logic [63:0] clamp64(logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = $signed({64'd0, MAXPOS});
      lo_lim = -$signed({64'd0, SIGN64});
      if (v > hi_lim) return MAXPOS;
      if (v < lo_lim) return SIGN64;
      return v[63:0];
   endfunction

   function automatic logic [63:0] fx_bool(bit b);
      return b ? (64'd1 << FRAC) : 64'd0;
   endfunction

   // Two-operand arithmetic and logic on Q32.32 values
   function automatic logic [63:0] binary_result(logic [4:0] opcode, logic [63:0] a,
                                                 logic [63:0] b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] wr;
      wa = $signed(a);
      wb = $signed(b);
      case (opcode)
         OP_ADD: return clamp64(wa + wb);
         OP_SUB: return clamp64(wa - wb);
         OP_MUL: begin
            wr = wa * wb;
            return clamp64(wr >>> FRAC);
         end
         OP_DIV: begin
            if (b == 0) return (a == 0) ? 64'd0 : (a[63] ? SIGN64 : MAXPOS);
            wr = (wa <<< FRAC) / wb;
            return clamp64(wr);
         end
         OP_EQ:  return fx_bool(a == b);
         OP_NEQ: return fx_bool(a != b);
         OP_LT:  return fx_bool($signed(a) < $signed(b));
         OP_LTE: return fx_bool($signed(a) <= $signed(b));
         OP_GT:  return fx_bool($signed(a) > $signed(b));
         OP_GTE: return fx_bool($signed(a) >= $signed(b));
         OP_AND: return fx_bool(a != 0 && b != 0);
         default: return fx_bool(a != 0 || b != 0);
      endcase
   endfunction

   // Execute one instruction against the shadow stack
   function automatic outcome_type execute_instr(instr_type it);
      outcome_type r;
      int idx;
      int sp;
      logic [17:0] jump_adv;
      idx = $signed(it.index);
      sp = shadow_sp;
      jump_adv = 18'($signed(it.index)) + 18'd1;
      r.pc_adv = 18'd1;
      r.status = STAT_OK;
      if (it.opcode <= OP_NOT) begin
         if (sp < 1) r.status = STAT_UNDER;
         else if (it.opcode == OP_NEG)
            shadow_mem[sp-1] = clamp64(-$signed({{64{shadow_mem[sp-1][63]}},
                                                  shadow_mem[sp-1]}));
         else shadow_mem[sp-1] = fx_bool(shadow_mem[sp-1] == 0);
      end else if (it.opcode <= OP_OR) begin
         if (sp < 2) r.status = STAT_UNDER;
         else begin
            if (it.opcode == OP_DIV && shadow_mem[sp-1] == 0) r.status = STAT_DIVZERO;
            shadow_mem[sp-2] = binary_result(it.opcode, shadow_mem[sp-2], shadow_mem[sp-1]);
            sp--;
         end
      end else if (it.opcode == OP_LOAD) begin
         r.pc_adv = 18'd2;
         if (sp >= DEPTH) r.status = STAT_OVER;
         else if (idx < 0 || idx >= DEPTH) r.status = STAT_INDEX;
         else begin
            shadow_mem[sp] = shadow_mem[idx];
            sp++;
         end
      end else if (it.opcode == OP_SAVE) begin
         r.pc_adv = 18'd2;
         if (sp < 1) r.status = STAT_UNDER;
         else if (idx < 0 || idx >= DEPTH) r.status = STAT_INDEX;
         else begin
            sp--;
            shadow_mem[idx] = shadow_mem[sp];
         end
      end else if (it.opcode <= OP_PUSH_ZERO) begin
         if (it.opcode == OP_PUSH) r.pc_adv = 18'd2;
         if (sp >= DEPTH) r.status = STAT_OVER;
         else begin
            shadow_mem[sp] = (it.opcode == OP_PUSH) ? it.literal
                                                    : fx_bool(it.opcode == OP_TRUE);
            sp++;
         end
      end else if (it.opcode == OP_JUMP) begin
         r.pc_adv = jump_adv;
      end else if (it.opcode == OP_JUMPIF) begin
         r.pc_adv = 18'd2;
         if (sp < 1) r.status = STAT_UNDER;
         else begin
            if (shadow_mem[sp-1] == 0) r.pc_adv = jump_adv;
            sp--;
         end
      end else if (it.opcode == OP_ADJUST) begin
         r.pc_adv = 18'd2;
         if (idx < 0 || idx > DEPTH) r.status = STAT_INDEX;
         else sp = idx;
      end
      shadow_sp = sp;
      r.top = (sp > 0) ? shadow_mem[sp-1] : 64'd0;
      r.depth = 7'(sp);
      return r;
   endfunction

   // Stack depth the generator expects after an instruction
   function automatic int next_depth(instr_type it, int d);
      int idx;
      idx = $signed(it.index);
      if (it.opcode <= OP_NOT) return d;
      if (it.opcode <= OP_OR) return (d >= 2) ? d - 1 : d;
      if (it.opcode == OP_LOAD) return (d < DEPTH && idx >= 0 && idx < DEPTH) ? d + 1 : d;
      if (it.opcode == OP_SAVE) return (d >= 1 && idx >= 0 && idx < DEPTH) ? d - 1 : d;
      if (it.opcode <= OP_PUSH_ZERO) return (d < DEPTH) ? d + 1 : d;
      if (it.opcode == OP_JUMPIF) return (d >= 1) ? d - 1 : d;
      if (it.opcode == OP_ADJUST) return (idx >= 0 && idx <= DEPTH) ? idx : d;
      return d;
   endfunction

   task automatic queue_instr(logic [4:0] opcode, logic [63:0] literal, logic [16:0] index);
      instr_type it;
      it.opcode = opcode;
      it.literal = literal;
      it.index = index;
      plan_depth = next_depth(it, plan_depth);
      pending_instrs.push_back(it);
   endtask

   function automatic logic [63:0] random_literal();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return 64'd0;
         1: return $urandom_range(1) ? SIGN64 : MAXPOS;
         2: return $urandom_range(1) ? (64'd1 << FRAC) : -(64'd1 << FRAC);
         3, 4: return {{29{v[63]}}, v[34:0]};   // modest Q32.32 values
         default: return v;
      endcase
   endfunction

   // One random instruction, mostly well formed for the planned depth
   task automatic queue_random();
      logic [4:0]  opcode;
      logic [16:0] index;
      index = 17'($urandom_range(DEPTH - 1));
      if ($urandom_range(99) < 10) begin
         opcode = 5'($urandom_range(31));
         index = 17'($urandom);
      end else if (plan_depth < 2 || (plan_depth < 56 && $urandom_range(2) == 0)) begin
         case ($urandom_range(5))
            0: opcode = OP_TRUE;
            1: opcode = OP_PUSH_ZERO;
            2: opcode = OP_LOAD;
            default: opcode = OP_PUSH;
         endcase
      end else begin
         opcode = 5'($urandom_range(OP_ADJUST));
         if (opcode == OP_ADJUST) index = 17'($urandom_range(DEPTH));
         if (opcode == OP_JUMP || opcode == OP_JUMPIF) index = 17'($urandom);
      end
      queue_instr(opcode, random_literal(), index);
   endtask

   task automatic drain();
      while (pending_instrs.size() > 0 || req_tvalid || expected_outcomes.size() > 0)
         @(posedge clock);
   endtask

   // Input driver and ready generator
   always @(negedge clock) begin
      instr_type it;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_instrs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, it.index, it.literal};
            req_tuser <= it.opcode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Accepted instructions feed the predictor
   always @(posedge clock) begin
      instr_type it;
      req_taken = req_tvalid && req_tready;
      if (req_taken) begin
         it.opcode = req_tuser;
         it.literal = req_tdata[63:0];
         it.index = req_tdata[80:64];
         expected_outcomes.push_back(execute_instr(it));
      end
   end

   // Result checker
   always @(posedge clock) begin
      outcome_type exp_r;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", rsp_tdata);
         end else begin
            exp_r = expected_outcomes.pop_front();
            if (rsp_tdata[17:0] !== exp_r.pc_adv || rsp_tdata[81:18] !== exp_r.top ||
                rsp_tdata[88:82] !== exp_r.depth || rsp_tdata[91:89] !== exp_r.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp adv %h top %h depth %0d status %0d, got %h %h %0d %0d",
                           exp_r.pc_adv, exp_r.top, exp_r.depth, exp_r.status,
                           rsp_tdata[17:0], rsp_tdata[81:18], rsp_tdata[88:82],
                           rsp_tdata[91:89]);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_mem[i] = 64'd0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: underflow on empty stack, saturation, divide by zero, bad indexes, jumps, an unknown opcode
      queue_instr(OP_NEG, 0, 0);
      queue_instr(OP_ADD, 0, 0);
      queue_instr(OP_SAVE, 0, 0);
      queue_instr(OP_JUMPIF, 0, 0);
      queue_instr(OP_PUSH, MAXPOS, 0);
      queue_instr(OP_TRUE, 0, 0);
      queue_instr(OP_ADD, 0, 0);
      queue_instr(OP_PUSH, SIGN64, 0);
      queue_instr(OP_NEG, 0, 0);
      queue_instr(OP_MUL, 0, 0);
      queue_instr(OP_PUSH, SIGN64, 0);
      queue_instr(OP_PUSH_ZERO, 0, 0);
      queue_instr(OP_DIV, 0, 0);
      queue_instr(OP_PUSH_ZERO, 0, 0);
      queue_instr(OP_DIV, 0, 0);
      queue_instr(OP_LOAD, 0, 17'h1FFFF);
      queue_instr(OP_LOAD, 0, 17'd64);
      queue_instr(OP_SAVE, 0, 17'd63);
      queue_instr(OP_ADJUST, 0, 17'd65);
      queue_instr(OP_ADJUST, 0, 17'd64);
      queue_instr(OP_PUSH, 64'h5555_AAAA_0F0F_F0F0, 0);
      queue_instr(OP_LOAD, 0, 17'd63);
      queue_instr(OP_ADJUST, 0, 17'd3);
      queue_instr(OP_JUMP, 0, 17'h10000);
      queue_instr(OP_JUMP, 0, 17'h0FFFF);
      queue_instr(OP_JUMPIF, 0, 17'd7);
      queue_instr(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF);
      for (int op = OP_SUB; op <= OP_OR; op++) begin
         queue_instr(OP_PUSH, random_literal(), 0);
         queue_instr(OP_PUSH, random_literal(), 0);
         queue_instr(5'(op), 0, 0);
      end
      queue_instr(OP_NOT, 0, 0);

      // Random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 74 : (phase == 3) ? 36 : 0;
         recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 36 : 0;
         repeat (350) queue_random();
         drain();
      end
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0 && !timed_out)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
   end

endmodule
